[rtl/tga_rle_pkg.sv]
package tga_rle_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [31:0] cfg_data_t;
  typedef logic [1:0]  fmt_t;

  localparam fmt_t FMT_RGB555 = 2'd0;
  localparam fmt_t FMT_BGR24  = 2'd1;
  localparam fmt_t FMT_BGRA32 = 2'd2;

  localparam cfg_idx_t REG_PIXEL_FORMAT = 2'd0;
  localparam cfg_idx_t REG_RLE_ENABLE   = 2'd1;
  localparam cfg_idx_t REG_PIXEL_COUNT  = 2'd2;

  localparam byte_t ALPHA_OPAQUE = 8'hFF;

  // floor(x * 255 / 31) for a 5-bit channel, as 8x + floor(7x / 31);
  // floor(7x / 31) == floor(x * 232 / 1024) for every 5-bit x
  function automatic byte_t expand5(input logic [4:0] x);
    logic [12:0] prod;
    prod = 13'(x) * 13'd232;
    return {x, 3'b000} + {5'd0, prod[12:10]};
  endfunction

endpackage

[rtl/tga_rle_ifs.sv]
interface tga_rle_byte_if;
  import tga_rle_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tga_rle_pixel_if;
  import tga_rle_pkg::*;
  logic  valid;
  logic  ready;
  byte_t blue;
  byte_t green;
  byte_t red;
  byte_t alpha;
  byte_t repeat_count;
  logic  image_done;
  modport source (output valid, output blue, output green, output red, output alpha,
                  output repeat_count, output image_done, input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha,
                  input repeat_count, input image_done, output ready);
endinterface

interface tga_rle_cfg_if;
  import tga_rle_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tga_rle_pixel_decoder_unit.sv]
// Timing: a byte that completes a pixel shows its result on the output in the
// cycle after its transfer; header bytes and leading pixel bytes give none.
// Throughput: one byte per cycle, set by the packet/pixel state update; the
// input stalls only while a result waits and is not taken.
// Reset (synchronous, rst high) and any register write restart the image.
module tga_rle_pixel_decoder_unit (
  input logic             clk,
  input logic             rst,
  tga_rle_byte_if.sink    stream,
  tga_rle_pixel_if.source pixel,
  tga_rle_cfg_if.sink     cfg
);
  import tga_rle_pkg::*;

  fmt_t        pixel_format;
  logic        rle_enable;
  logic [31:0] pixel_count;

  logic        expect_header;
  logic [1:0]  byte_position;
  logic        packet_is_run;
  logic [7:0]  packet_pixels_left;
  logic [23:0] partial_pixel;
  logic [31:0] image_pixels_left;

  logic        out_valid;
  byte_t       blue, green, red, alpha, repeat_count;
  logic        image_done;

  logic        in_xfer, cfg_xfer, cfg_hit;
  logic        is_header, pixel_last;
  logic [2:0]  nbytes;
  logic [31:0] count_eff;
  logic [15:0] word;
  byte_t       blue_next, green_next, red_next, alpha_next;
  byte_t       rep_raw, rep_next;
  logic [7:0]  ppl_next;
  logic [31:0] ipl_next;
  logic        done_next;

  assign stream.ready = !out_valid || pixel.ready;
  assign cfg.ready    = 1'b1;
  assign in_xfer      = stream.valid && stream.ready;
  assign cfg_xfer     = cfg.valid;
  assign cfg_hit      = cfg_xfer && (cfg.index == REG_PIXEL_FORMAT ||
                        cfg.index == REG_RLE_ENABLE || cfg.index == REG_PIXEL_COUNT);

  assign count_eff  = (pixel_count == '0) ? 32'd1 : pixel_count;
  assign is_header  = rle_enable && expect_header;
  assign pixel_last = ({1'b0, byte_position} + 3'd1) >= nbytes;
  assign word       = {stream.in_byte, partial_pixel[7:0]};

  always_comb begin
    unique case (pixel_format)
      FMT_RGB555: nbytes = 3'd2;
      FMT_BGR24:  nbytes = 3'd3;
      default:    nbytes = 3'd4;
    endcase
  end

  always_comb begin
    blue_next  = partial_pixel[7:0];
    green_next = partial_pixel[15:8];
    red_next   = partial_pixel[23:16];
    alpha_next = stream.in_byte;
    unique case (pixel_format)
      FMT_RGB555: begin
        blue_next  = expand5(word[4:0]);
        green_next = expand5(word[9:5]);
        red_next   = expand5(word[14:10]);
        alpha_next = ALPHA_OPAQUE;
      end
      FMT_BGR24: begin
        red_next   = stream.in_byte;
        alpha_next = ALPHA_OPAQUE;
      end
      default: ;
    endcase
  end

  always_comb begin
    rep_raw  = 8'd1;
    ppl_next = packet_pixels_left;
    if (rle_enable) begin
      if (packet_is_run) begin
        rep_raw  = packet_pixels_left;
        ppl_next = '0;
      end else if (packet_pixels_left != '0) begin
        ppl_next = packet_pixels_left - 8'd1;
      end
      if (rep_raw == '0) begin
        rep_raw = 8'd1;
      end
    end
    rep_next  = ({24'd0, rep_raw} > image_pixels_left) ? image_pixels_left[7:0] : rep_raw;
    ipl_next  = image_pixels_left - {24'd0, rep_next};
    done_next = (ipl_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format       <= FMT_BGRA32;
      rle_enable         <= 1'b0;
      pixel_count        <= 32'd1;
      expect_header      <= 1'b0;
      byte_position      <= '0;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      partial_pixel      <= '0;
      image_pixels_left  <= 32'd1;
    end else if (cfg_hit) begin
      unique case (cfg.index)
        REG_PIXEL_FORMAT: begin
          pixel_format      <= cfg.data[1:0];
          expect_header     <= rle_enable;
          image_pixels_left <= count_eff;
        end
        REG_RLE_ENABLE: begin
          rle_enable        <= cfg.data[0];
          expect_header     <= cfg.data[0];
          image_pixels_left <= count_eff;
        end
        default: begin
          pixel_count       <= cfg.data;
          expect_header     <= rle_enable;
          image_pixels_left <= (cfg.data == '0) ? 32'd1 : cfg.data;
        end
      endcase
      byte_position      <= '0;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      partial_pixel      <= '0;
    end else if (in_xfer) begin
      priority if (is_header) begin
        packet_is_run      <= stream.in_byte[7];
        packet_pixels_left <= {1'b0, stream.in_byte[6:0]} + 8'd1;
        expect_header      <= 1'b0;
        byte_position      <= '0;
      end else if (!pixel_last) begin
        unique case (byte_position)
          2'd0:    partial_pixel[7:0]   <= stream.in_byte;
          2'd1:    partial_pixel[15:8]  <= stream.in_byte;
          default: partial_pixel[23:16] <= stream.in_byte;
        endcase
        byte_position <= byte_position + 2'd1;
      end else if (done_next) begin
        expect_header      <= rle_enable;
        byte_position      <= '0;
        packet_is_run      <= 1'b0;
        packet_pixels_left <= '0;
        partial_pixel      <= '0;
        image_pixels_left  <= count_eff;
      end else begin
        byte_position      <= '0;
        partial_pixel      <= '0;
        packet_pixels_left <= ppl_next;
        if (rle_enable && ppl_next == '0) begin
          expect_header <= 1'b1;
        end
        image_pixels_left  <= ipl_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && !is_header && pixel_last) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !is_header && pixel_last) begin
      blue         <= blue_next;
      green        <= green_next;
      red          <= red_next;
      alpha        <= alpha_next;
      repeat_count <= rep_next;
      image_done   <= done_next;
    end
  end

  assign pixel.valid        = out_valid;
  assign pixel.blue         = blue;
  assign pixel.green        = green;
  assign pixel.red          = red;
  assign pixel.alpha        = alpha;
  assign pixel.repeat_count = repeat_count;
  assign pixel.image_done   = image_done;

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, byte_position} < nbytes))
    else $error("byte position past pixel size");

  a_pixels_left: assert property (@(posedge clk) disable iff (rst)
    (image_pixels_left != '0))
    else $error("image pixel counter reached zero without restart");

  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    pixel.valid |-> (pixel.repeat_count != '0 && pixel.repeat_count <= 8'd128))
    else $error("repeat count out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> out_valid)
    else $error("input stalled with empty result register");

endmodule
